// File: src/okb_pkg.sv
// shared constants and register index codes for the octree key bisection block
package okb_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int DEPTH_BITS     = 4;
   localparam int LVL_BITS       = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_WIDTH    = 3'd3,
      CSR_DEPTH    = 3'd4
   } csr_index_type;

   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 4'd8;
   localparam int                    WIDTH_RESET = 65536;

endpackage

// File: src/octree_key_bisection.sv
// octree key of one point by per-level bisection of a configured root cube
//
//   channel   dir   handshake            beat
//   req_      in    req_valid/req_ready  point x, y, z and batch end flag
//   rsp_      out   rsp_valid/rsp_ready  node key, leaf center x, y, z, batch end echo
//   csr_      in    csr_we               register index and write data
//
// one point per cycle while the output is not stalled; one pipeline stage per level
// plus an entry stage (root interval) and an output stage (saturation).
// synchronous reset restores the configuration defaults and clears all valid bits.
// one enable moves every stage; when the output holds a beat that is not
// taken the whole pipeline and req_ready stall, nothing is dropped or repeated.
module octree_key_bisection #(
   parameter int MAX_LEVELS = 10,
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_BITS-1:0]          req_point_x,
   input  logic signed [COORD_BITS-1:0]          req_point_y,
   input  logic signed [COORD_BITS-1:0]          req_point_z,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [3*MAX_LEVELS-1:0]               rsp_node_key,
   output logic signed [COORD_BITS-1:0]          rsp_leaf_center_x,
   output logic signed [COORD_BITS-1:0]          rsp_leaf_center_y,
   output logic signed [COORD_BITS-1:0]          rsp_leaf_center_z,
   output logic                                  rsp_last_key,
   input  logic                                  csr_we,
   input  logic [okb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wdata
);
   import okb_pkg::*;

   localparam int W  = COORD_BITS + 2;
   localparam int KW = 3 * MAX_LEVELS;

   typedef struct packed {
      logic [W-1:0] mid;
      logic [W-1:0] lo;
      logic [W-1:0] hi;
   } axis_type;

   typedef struct packed {
      axis_type [2:0]                 ax;
      logic [2:0][COORD_BITS-1:0]     pt;
      logic [KW-1:0]                  key;
      logic                           last;
   } stage_type;

   // configuration
   logic [COORD_BITS-1:0]   center_x_ff, center_y_ff, center_z_ff;
   logic [COORD_BITS-2:0]   width_ff;
   logic [DEPTH_BITS-1:0]   depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         width_ff    <= (COORD_BITS-1)'(WIDTH_RESET);
         depth_ff    <= DEPTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_WIDTH:    width_ff    <= csr_wdata[COORD_BITS-2:0];
            CSR_DEPTH:    depth_ff    <= csr_wdata[DEPTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // one level on all three axes when act: compare, keep a half, new floor midpoint
   function automatic stage_type level_step(input stage_type st, input logic act);
      stage_type        res;
      logic signed [W-1:0] pe;
      logic signed [W-1:0] sum;
      logic [2:0]       b;
      axis_type         a;
      res = st;
      b   = '0;
      for (int k = 0; k < 3; k++) begin
         a  = st.ax[k];
         pe = W'($signed(st.pt[k]));
         if (pe < $signed(a.mid)) begin
            a.hi = a.mid;
            b[2-k] = 1'b0;
         end else begin
            a.lo = a.mid;
            b[2-k] = 1'b1;
         end
         sum   = $signed(a.lo) + $signed(a.hi);
         a.mid = sum >>> 1;
         if (act) begin
            res.ax[k] = a;
         end
      end
      if (act) begin
         res.key = (st.key << 3) | KW'(b);
      end
      return res;
   endfunction

   function automatic logic [COORD_BITS-1:0] saturate(input logic [W-1:0] v);
      logic [W-COORD_BITS:0] top;
      top = v[W-1:COORD_BITS-1];
      if ((top == '0) || (top == '1)) begin
         return v[COORD_BITS-1:0];
      end else if (v[W-1]) begin
         return {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   endfunction

   stage_type  stage_in [MAX_LEVELS+1];
   stage_type  stage_ff [MAX_LEVELS+1];
   logic [MAX_LEVELS:0] valid_ff;
   logic       out_valid_ff;
   logic       en;

   logic [KW-1:0]         key_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic                  last_ff;

   assign en = !out_valid_ff || rsp_ready;

   // entry stage root interval [center - half, center + half] and the level steps
   always_comb begin
      logic [W-1:0] half;
      logic [2:0][COORD_BITS-1:0] ctr;
      half = W'(width_ff >> 1);
      ctr  = {center_z_ff, center_y_ff, center_x_ff};
      stage_in[0].pt   = {req_point_z, req_point_y, req_point_x};
      stage_in[0].key  = '0;
      stage_in[0].last = req_last_point;
      for (int k = 0; k < 3; k++) begin
         stage_in[0].ax[k].mid = W'($signed(ctr[k]));
         stage_in[0].ax[k].lo  = W'($signed(ctr[k])) - half;
         stage_in[0].ax[k].hi  = W'($signed(ctr[k])) + half;
      end
      for (int s = 1; s <= MAX_LEVELS; s++) begin
         stage_in[s] = level_step(stage_ff[s-1],
                                  {1'b0, depth_ff} > LVL_BITS'(s-1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= MAX_LEVELS; s++) begin
            stage_ff[s] <= stage_in[s];
         end
         key_ff  <= stage_ff[MAX_LEVELS].key;
         cx_ff   <= saturate(stage_ff[MAX_LEVELS].ax[0].mid);
         cy_ff   <= saturate(stage_ff[MAX_LEVELS].ax[1].mid);
         cz_ff   <= saturate(stage_ff[MAX_LEVELS].ax[2].mid);
         last_ff <= stage_ff[MAX_LEVELS].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[MAX_LEVELS-1:0], req_valid};
         out_valid_ff <= valid_ff[MAX_LEVELS];
      end
   end

   assign req_ready         = en;
   assign rsp_valid         = out_valid_ff;
   assign rsp_node_key      = key_ff;
   assign rsp_leaf_center_x = cx_ff;
   assign rsp_leaf_center_y = cy_ff;
   assign rsp_leaf_center_z = cz_ff;
   assign rsp_last_key      = last_ff;

endmodule

// File: src/okb_checker.sv
// port-level checks for the octree key bisection block and their bind
module okb_checker #(
   parameter int MAX_LEVELS = 10,
   parameter int COORD_BITS = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [3*MAX_LEVELS-1:0]      rsp_node_key,
   input logic [COORD_BITS-1:0]        rsp_leaf_center_x,
   input logic                         rsp_last_key
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_key)
         && $stable(rsp_leaf_center_x) && $stable(rsp_last_key))
      else $error("stalled result beat changed");

   // a stalled output freezes the pipeline, so no new beat enters
   assert property (@(posedge clock) rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   // empty output never blocks the input
   assert property (@(posedge clock) !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind octree_key_bisection okb_checker #(
   .MAX_LEVELS(MAX_LEVELS),
   .COORD_BITS(COORD_BITS)
) u_okb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_node_key      (rsp_node_key),
   .rsp_leaf_center_x (rsp_leaf_center_x),
   .rsp_last_key      (rsp_last_key)
);
